FILE: hw/rtl/rp4_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rp4_pkg
// Types, constants and the orientation helper shared by the four-point
// partition block.
// ----------------------------------------------------------------------------
package rp4_pkg;

  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned DIFF_W     = COORD_BITS + 1;
  localparam int unsigned PROD_W     = 2 * DIFF_W;
  localparam int unsigned NUM_PTS    = 4;
  localparam int unsigned NUM_TRI    = 4;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;

  typedef enum logic [1:0] {
    LAYOUT_QUAD = 2'd0,
    LAYOUT_TRI  = 2'd1,
    LAYOUT_LINE = 2'd2
  } layout_e;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by_coord;
    coord_t cx;
    coord_t cy;
    coord_t dx;
    coord_t dy;
  } in_beat_t;

  typedef struct packed {
    logic [NUM_PTS-1:0] first_set;
    logic [NUM_PTS-1:0] second_set;
    layout_e            layout;
  } out_beat_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  // sign of a cross product; both low means zero
  typedef struct packed {
    logic pos;
    logic neg;
  } sign_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

  // pairwise signed less-than: ltx[i][j] = x(i) < x(j)
  typedef struct packed {
    logic [NUM_PTS-1:0][NUM_PTS-1:0] ltx;
    logic [NUM_PTS-1:0][NUM_PTS-1:0] lty;
  } rel_t;

  // base triples, lane t leaves out point NUM_PTS-1-t
  localparam int unsigned TRI_A [NUM_TRI] = '{0, 0, 0, 1};
  localparam int unsigned TRI_B [NUM_TRI] = '{1, 1, 2, 2};
  localparam int unsigned TRI_C [NUM_TRI] = '{2, 3, 3, 3};

  // orientation of (i, j, k), distinct indices, from the base triple signs
  function automatic sign_t orient3(input sign_t [NUM_TRI-1:0] o,
                                    input int i, input int j, input int k);
    int    m;
    int    inv;
    sign_t s;
    m   = 6 - i - j - k;
    inv = int'(i > j) + int'(i > k) + int'(j > k);
    s   = o[2'(NUM_TRI - 1 - m)];
    if (inv[0]) begin
      orient3 = '{pos: s.neg, neg: s.pos};
    end else begin
      orient3 = s;
    end
  endfunction

  function automatic logic is_zero(input sign_t s);
    is_zero = !(s.pos || s.neg);
  endfunction

endpackage

FILE: hw/rtl/rp4_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rp4_lane
// One orientation lane: sign of (b - a) x (c - a), exact, over three stages
// (differences, products, compare).
// ----------------------------------------------------------------------------
module rp4_lane
  import rp4_pkg::*;
(
  input  logic      clk_i,
  input  stage_en_t en_i,
  input  point_t    a_i,
  input  point_t    b_i,
  input  point_t    c_i,
  output sign_t     sign_o
);

  diff_t bax_q, bay_q, cax_q, cay_q;
  prod_t lhs_q, rhs_q;
  sign_t sign_q;

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      bax_q <= diff_t'(b_i.x) - diff_t'(a_i.x);
      bay_q <= diff_t'(b_i.y) - diff_t'(a_i.y);
      cax_q <= diff_t'(c_i.x) - diff_t'(a_i.x);
      cay_q <= diff_t'(c_i.y) - diff_t'(a_i.y);
    end
    if (en_i.s2) begin
      lhs_q <= prod_t'(bax_q) * prod_t'(cay_q);
      rhs_q <= prod_t'(bay_q) * prod_t'(cax_q);
    end
    if (en_i.s3) begin
      sign_q.pos <= lhs_q > rhs_q;
      sign_q.neg <= lhs_q < rhs_q;
    end
  end

  assign sign_o = sign_q;

endmodule

FILE: hw/rtl/rp4_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rp4_merge
// Combines the lane signs and coordinate order into hull vertices, the
// layout code and the two point sets.
// ----------------------------------------------------------------------------
module rp4_merge
  import rp4_pkg::*;
(
  input  sign_t [NUM_TRI-1:0] orient_i,
  input  rel_t                rel_i,
  output out_beat_t           beat_o
);

  logic [NUM_PTS-1:0][NUM_PTS-1:0] eq;
  logic [NUM_PTS-1:0][NUM_PTS-1:0] le_x, le_y, lex_lt;
  logic [NUM_PTS-1:0]              rep, vert;
  logic [NUM_PTS-1:0][NUM_PTS-1:0] diag;
  logic [1:0]                      piv;
  logic                            coll, quad;

  always_comb begin
    for (int i = 0; i < NUM_PTS; i++) begin
      for (int j = 0; j < NUM_PTS; j++) begin
        le_x[i][j] = !rel_i.ltx[j][i];
        le_y[i][j] = !rel_i.lty[j][i];
      end
    end
    for (int i = 0; i < NUM_PTS; i++) begin
      for (int j = 0; j < NUM_PTS; j++) begin
        eq[i][j]     = le_x[i][j] && le_x[j][i] && le_y[i][j] && le_y[j][i];
        lex_lt[i][j] = rel_i.ltx[i][j] ||
                       (le_x[i][j] && le_x[j][i] && rel_i.lty[i][j]);
      end
    end
    for (int i = 0; i < NUM_PTS; i++) begin
      rep[i] = 1'b1;
      for (int j = 0; j < i; j++) begin
        if (eq[i][j]) rep[i] = 1'b0;
      end
    end
  end

  // strict hull vertices
  always_comb begin
    logic  covered;
    int    a, b, c;
    sign_t o1, o2, o3;
    for (int i = 0; i < NUM_PTS; i++) begin
      covered = 1'b0;
      for (int j = 0; j < NUM_PTS; j++) begin
        for (int k = j + 1; k < NUM_PTS; k++) begin
          if (j != i && k != i && rep[j] && rep[k] &&
              is_zero(orient3(orient_i, j, k, i)) &&
              ((le_x[j][i] && le_x[i][k]) || (le_x[k][i] && le_x[i][j])) &&
              ((le_y[j][i] && le_y[i][k]) || (le_y[k][i] && le_y[i][j]))) begin
            covered = 1'b1;
          end
        end
      end
      a = (i == 0) ? 1 : 0;
      b = (i <= 1) ? 2 : 1;
      c = (i <= 2) ? 3 : 2;
      o1 = orient3(orient_i, a, b, i);
      o2 = orient3(orient_i, b, c, i);
      o3 = orient3(orient_i, c, a, i);
      if (rep[a] && rep[b] && rep[c] && !is_zero(orient3(orient_i, a, b, c)) &&
          ((!o1.neg && !o2.neg && !o3.neg) || (!o1.pos && !o2.pos && !o3.pos))) begin
        covered = 1'b1;
      end
      vert[i] = rep[i] && !covered;
    end
  end

  // collinearity, pivot and diagonals
  always_comb begin
    int    u, v;
    sign_t su, sv;
    coll = 1'b1;
    for (int t = 0; t < NUM_TRI; t++) begin
      if (rep[TRI_A[t]] && rep[TRI_B[t]] && rep[TRI_C[t]] && !is_zero(orient_i[t])) begin
        coll = 1'b0;
      end
    end
    piv = 2'd0;
    for (int i = 1; i < NUM_PTS; i++) begin
      if (lex_lt[i][piv]) piv = 2'(i);
    end
    for (int pv = 0; pv < NUM_PTS; pv++) begin
      diag[pv] = '0;
      diag[pv][pv] = 1'b1;
      for (int i = 0; i < NUM_PTS; i++) begin
        if (i != pv) begin
          u = -1;
          v = -1;
          for (int j = 0; j < NUM_PTS; j++) begin
            if (j != pv && j != i) begin
              if (u < 0) u = j;
              else       v = j;
            end
          end
          su = orient3(orient_i, pv, i, u);
          sv = orient3(orient_i, pv, i, v);
          diag[pv][i] = (su.pos && sv.neg) || (su.neg && sv.pos);
        end
      end
    end
    quad = &vert;
  end

  always_comb begin
    beat_o.first_set  = (quad && !coll) ? diag[piv] : vert;
    beat_o.second_set = ~beat_o.first_set;
    if (coll) begin
      beat_o.layout = LAYOUT_LINE;
    end else if (quad) begin
      beat_o.layout = LAYOUT_QUAD;
    end else begin
      beat_o.layout = LAYOUT_TRI;
    end
  end

endmodule

FILE: hw/rtl/radon_partition_four_points.sv
`timescale 1ns / 1ps
// The result beat passes stages s1, s2, s3 and the output register to out_valid_o.
// One beat per cycle unless stalled; four orientation lanes, two 17x17 products each.
// A stalled output holds only the stages behind it that are full; bubbles still fill.
// Reset clears the stage valid bits only; no other state is kept.
// ----------------------------------------------------------------------------
// radon_partition_four_points
// Splits four plane points into two sets with intersecting convex hulls.
// ----------------------------------------------------------------------------
module radon_partition_four_points
  import rp4_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_beat_o
);

  point_t [NUM_PTS-1:0] pts;
  rel_t                 rel_d, rel1_q, rel2_q, rel3_q;
  sign_t [NUM_TRI-1:0]  orient;
  out_beat_t            beat_d, beat_q;
  stage_en_t            en;
  logic                 en_out;
  logic                 v1_q, v2_q, v3_q, vout_q;

  assign pts[0] = '{x: in_beat_i.ax, y: in_beat_i.ay};
  assign pts[1] = '{x: in_beat_i.bx, y: in_beat_i.by_coord};
  assign pts[2] = '{x: in_beat_i.cx, y: in_beat_i.cy};
  assign pts[3] = '{x: in_beat_i.dx, y: in_beat_i.dy};

  always_comb begin
    for (int i = 0; i < NUM_PTS; i++) begin
      for (int j = 0; j < NUM_PTS; j++) begin
        rel_d.ltx[i][j] = pts[i].x < pts[j].x;
        rel_d.lty[i][j] = pts[i].y < pts[j].y;
      end
    end
  end

  assign en_out     = !vout_q || out_ready_i;
  assign en.s3      = !v3_q || en_out;
  assign en.s2      = !v2_q || en.s3;
  assign en.s1      = !v1_q || en.s2;
  assign in_ready_o = en.s1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      vout_q <= 1'b0;
    end else begin
      if (en.s1)  v1_q   <= in_valid_i;
      if (en.s2)  v2_q   <= v1_q;
      if (en.s3)  v3_q   <= v2_q;
      if (en_out) vout_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en.s1)  rel1_q <= rel_d;
    if (en.s2)  rel2_q <= rel1_q;
    if (en.s3)  rel3_q <= rel2_q;
    if (en_out) beat_q <= beat_d;
  end

  for (genvar t = 0; t < NUM_TRI; t++) begin : g_lane
    rp4_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .a_i    (pts[TRI_A[t]]),
      .b_i    (pts[TRI_B[t]]),
      .c_i    (pts[TRI_C[t]]),
      .sign_o (orient[t])
    );
  end

  rp4_merge u_merge (
    .orient_i (orient),
    .rel_i    (rel3_q),
    .beat_o   (beat_d)
  );

  assign out_valid_o = vout_q;
  assign out_beat_o  = beat_q;

endmodule

FILE: hw/rtl/rp4_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rp4_checker
// Port-level checks on the beats of the four-point partition block.
// ----------------------------------------------------------------------------
module rp4_checker
  import rp4_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_beat_t  in_beat_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_beat_t out_beat_o
);

  a_sets_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_beat_o.second_set == ~out_beat_o.first_set) &&
                    (out_beat_o.first_set != '0))
    else $error("result sets do not split the points");

  a_quad_diag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.layout == LAYOUT_QUAD |->
      $countones(out_beat_o.first_set) == 2)
    else $error("convex layout without a two-point diagonal");

  a_tri_hull: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.layout == LAYOUT_TRI |->
      $countones(out_beat_o.first_set) == 3)
    else $error("triangle layout without three hull vertices");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_beat_o))
    else $error("stalled result beat changed");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_beat_i))
    else $error("waiting input beat changed");

endmodule

bind radon_partition_four_points rp4_checker u_rp4_checker (.*);

FILE: test/radon_partition_four_points_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radon_partition_four_points_tb
// Self-checking bench for the four-point partition block. Each point set
// accepted on the input channel is run through a local partition model
// (exact 64-bit cross products). The expected masks and layout are queued,
// and every result beat is compared against the oldest entry. Stimulus covers
// directed corner shapes, then random sets biased toward collinear,
// coincident, interior and on-edge layouts. Random gaps and stalls run on
// both channels, plus a long output hold and full drains.
// ----------------------------------------------------------------------------
module radon_partition_four_points_tb;
  import rp4_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PRINT_CAP   = 40;

  typedef struct {
    in_beat_t  pts;
    out_beat_t want;
  } part_exp_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_beat_t  in_beat   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_beat;

  part_exp_t pending_parts[$];
  part_exp_t head;
  bit        tx_idle     = 1'b1;
  bit        rx_idle     = 1'b1;
  int        rx_hold_req = 0;
  int        mismatches  = 0;
  int        results_seen = 0;
  int        sets_sent   = 0;
  int        layout_count[3] = '{0, 0, 0};
  int        cycles      = 0;
  int        stall_cycles = 0;

  radon_partition_four_points uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_beat_i  (in_beat),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_beat_o (out_beat)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // partition model
  // --------------------------------------------------------------------------
  function automatic int orient_sign(int ax, int ay, int bx, int by, int cx, int cy);
    longint d;
    d = longint'(bx - ax) * longint'(cy - ay) - longint'(by - ay) * longint'(cx - ax);
    return (d > 0) ? 1 : ((d < 0) ? -1 : 0);
  endfunction

  function automatic bit in_span(int v, int a, int b);
    return (v >= ((a < b) ? a : b)) && (v <= ((a < b) ? b : a));
  endfunction

  function automatic bit on_segment(int px, int py, int ax, int ay, int bx, int by);
    return orient_sign(ax, ay, bx, by, px, py) == 0 && in_span(px, ax, bx) &&
           in_span(py, ay, by);
  endfunction

  function automatic bit in_triangle(int px, int py, int ax, int ay, int bx, int by,
                                     int cx, int cy);
    int o1, o2, o3;
    o1 = orient_sign(ax, ay, bx, by, px, py);
    o2 = orient_sign(bx, by, cx, cy, px, py);
    o3 = orient_sign(cx, cy, ax, ay, px, py);
    if (orient_sign(ax, ay, bx, by, cx, cy) == 0) begin
      return 1'b0;
    end
    return (o1 >= 0 && o2 >= 0 && o3 >= 0) || (o1 <= 0 && o2 <= 0 && o3 <= 0);
  endfunction

  function automatic out_beat_t partition_points(in_beat_t b);
    int         px[4], py[4];
    bit         uniq[4], hull[4];
    int         others[3];
    int         n, nhull, piv, u, v;
    bit         line_up, covered;
    logic [3:0] first;
    layout_e    lay;
    out_beat_t  r;
    px[0] = b.ax; py[0] = b.ay;
    px[1] = b.bx; py[1] = b.by_coord;
    px[2] = b.cx; py[2] = b.cy;
    px[3] = b.dx; py[3] = b.dy;
    for (int i = 0; i < 4; i++) begin
      uniq[i] = 1'b1;
      for (int j = 0; j < i; j++) begin
        if (px[j] == px[i] && py[j] == py[i]) uniq[i] = 1'b0;
      end
    end
    nhull = 0;
    for (int i = 0; i < 4; i++) begin
      hull[i] = 1'b0;
      if (uniq[i]) begin
        n = 0;
        covered = 1'b0;
        for (int j = 0; j < 4; j++) begin
          if (j != i && uniq[j]) begin
            others[n] = j;
            n++;
          end
        end
        for (int j = 0; j < n; j++) begin
          for (int k = j + 1; k < n; k++) begin
            if (on_segment(px[i], py[i], px[others[j]], py[others[j]],
                           px[others[k]], py[others[k]])) covered = 1'b1;
          end
        end
        if (n == 3 && in_triangle(px[i], py[i], px[others[0]], py[others[0]],
                                  px[others[1]], py[others[1]],
                                  px[others[2]], py[others[2]])) covered = 1'b1;
        hull[i] = !covered;
        if (hull[i]) nhull++;
      end
    end
    line_up = 1'b1;
    for (int i = 0; i < 4; i++) begin
      for (int j = i + 1; j < 4; j++) begin
        for (int k = j + 1; k < 4; k++) begin
          if (uniq[i] && uniq[j] && uniq[k] &&
              orient_sign(px[i], py[i], px[j], py[j], px[k], py[k]) != 0) line_up = 1'b0;
        end
      end
    end
    piv = 0;
    for (int i = 1; i < 4; i++) begin
      if (px[i] < px[piv] || (px[i] == px[piv] && py[i] < py[piv])) piv = i;
    end
    if (line_up) begin
      lay = LAYOUT_LINE;
    end else if (nhull == 4) begin
      lay = LAYOUT_QUAD;
    end else begin
      lay = LAYOUT_TRI;
    end
    first = '0;
    if (lay == LAYOUT_QUAD) begin
      first[piv] = 1'b1;
      for (int i = 0; i < 4; i++) begin
        if (i != piv) begin
          u = -1;
          v = -1;
          for (int j = 0; j < 4; j++) begin
            if (j != piv && j != i) begin
              if (u < 0) u = j;
              else v = j;
            end
          end
          if (orient_sign(px[piv], py[piv], px[i], py[i], px[u], py[u]) *
              orient_sign(px[piv], py[piv], px[i], py[i], px[v], py[v]) < 0) first[i] = 1'b1;
        end
      end
    end else begin
      for (int i = 0; i < 4; i++) first[i] = hull[i];
    end
    r.first_set  = first;
    r.second_set = ~first;
    r.layout     = lay;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic in_beat_t pts(int ax, int ay, int bx, int by, int cx, int cy,
                                   int dx, int dy);
    in_beat_t r;
    r.ax = coord_t'(ax); r.ay = coord_t'(ay);
    r.bx = coord_t'(bx); r.by_coord = coord_t'(by);
    r.cx = coord_t'(cx); r.cy = coord_t'(cy);
    r.dx = coord_t'(dx); r.dy = coord_t'(dy);
    return r;
  endfunction

  function automatic int rand_full();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int rand_edge_value();
    case ($urandom_range(0, 7))
      0: return -32768;
      1: return -32767;
      2: return -1;
      3: return 0;
      4: return 1;
      5: return 32766;
      6: return 32767;
      default: return 16384;
    endcase
  endfunction

  // biased toward degenerate shapes; points are shuffled at the end
  function automatic in_beat_t rand_points();
    int x[4], y[4];
    int bx, by, sx, sy, k, j, t;
    bx = int'($urandom_range(0, 40000)) - 20000;
    by = int'($urandom_range(0, 40000)) - 20000;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        for (int i = 0; i < 4; i++) begin
          x[i] = rand_full();
          y[i] = rand_full();
        end
      end
      3: begin
        for (int i = 0; i < 4; i++) begin
          x[i] = int'($urandom_range(0, 6)) - 3;
          y[i] = int'($urandom_range(0, 6)) - 3;
        end
      end
      4: begin
        sx = int'($urandom_range(0, 200)) - 100;
        sy = int'($urandom_range(0, 200)) - 100;
        for (int i = 0; i < 4; i++) begin
          k = int'($urandom_range(0, 100)) - 50;
          x[i] = bx + k * sx;
          y[i] = by + k * sy;
        end
      end
      5: begin
        for (int i = 0; i < 3; i++) begin
          x[i] = bx + int'($urandom_range(0, 2000)) - 1000;
          y[i] = by + int'($urandom_range(0, 2000)) - 1000;
        end
        x[3] = (x[0] + x[1] + x[2]) / 3;
        y[3] = (y[0] + y[1] + y[2]) / 3;
      end
      6: begin
        for (int i = 0; i < 4; i++) begin
          x[i] = rand_full();
          y[i] = rand_full();
        end
        for (int r = 0; r < int'($urandom_range(1, 2)); r++) begin
          k = $urandom_range(0, 3);
          j = (k + int'($urandom_range(1, 3))) % 4;
          x[j] = x[k];
          y[j] = y[k];
        end
      end
      7: begin
        for (int i = 0; i < 3; i++) begin
          x[i] = 2 * int'($urandom_range(0, 16000)) - 16000;
          y[i] = 2 * int'($urandom_range(0, 16000)) - 16000;
        end
        x[3] = (x[0] + x[1]) / 2;
        y[3] = (y[0] + y[1]) / 2;
      end
      8: begin
        for (int i = 0; i < 4; i++) begin
          x[i] = rand_edge_value();
          y[i] = rand_edge_value();
        end
      end
      default: begin
        for (int i = 0; i < 4; i++) begin
          x[i] = $urandom_range(0, 1) ? rand_full() : int'($urandom_range(0, 8)) - 4;
          y[i] = $urandom_range(0, 1) ? rand_full() : int'($urandom_range(0, 8)) - 4;
        end
      end
    endcase
    for (int i = 3; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = x[i]; x[i] = x[j]; x[j] = t;
      t = y[i]; y[i] = y[j]; y[j] = t;
    end
    return pts(x[0], y[0], x[1], y[1], x[2], y[2], x[3], y[3]);
  endfunction

  // --------------------------------------------------------------------------
  // channel drivers and checking
  // --------------------------------------------------------------------------
  task automatic send_points(input in_beat_t b);
    int        gap;
    part_exp_t e;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= b;
    do @(posedge clk); while (!in_ready);
    e.pts  = b;
    e.want = partition_points(b);
    pending_parts = {pending_parts, e};
    layout_count[e.want.layout]++;
    sets_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_parts.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP) $display("MISMATCH t=%0t %s", $time, msg);
    mismatches++;
  endtask

  initial begin : result_sink
    int gap;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (rx_hold_req > 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold_req) @(posedge clk);
        rx_hold_req = 0;
      end
      gap = rx_idle ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid && rx_hold_req == 0);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_parts.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing pending: %h", out_beat));
      end else begin
        head = pending_parts.pop_front();
        if (out_beat.first_set !== head.want.first_set)
          report_mismatch($sformatf("first_set %b want %b, points %h",
                                    out_beat.first_set, head.want.first_set, head.pts));
        if (out_beat.second_set !== head.want.second_set)
          report_mismatch($sformatf("second_set %b want %b, points %h",
                                    out_beat.second_set, head.want.second_set, head.pts));
        if (out_beat.layout !== head.want.layout)
          report_mismatch($sformatf("layout %0d want %0d, points %h",
                                    out_beat.layout, head.want.layout, head.pts));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (in_valid && !in_ready) stall_cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles,
               pending_parts.size());
      $display("status: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  task automatic test_directed_shapes();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    // identical points
    send_points(pts(0, 0, 0, 0, 0, 0, 0, 0));
    send_points(pts(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
    // convex quads, full-range and small, in several orders
    send_points(pts(-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767));
    send_points(pts(-32768, -32768, 32767, 32767, 32767, -32768, -32768, 32767));
    send_points(pts(32767, 32767, -32768, 32767, -32768, -32768, 32767, -32768));
    send_points(pts(-1, -1, 1, -1, 1, 1, -1, 1));
    send_points(pts(0, 0, 2, 1, 4, 0, 2, -1));
    send_points(pts(0, 0, 0, 4, 4, 4, 4, 0));
    // pivot tie on x
    send_points(pts(0, 5, 0, -5, 10, 10, 10, -10));
    // triangle with interior point
    send_points(pts(0, 0, 100, 0, 0, 100, 10, 10));
    send_points(pts(10, 10, 0, 0, 100, 0, 0, 100));
    send_points(pts(-32768, -32768, 32767, -32768, 0, 32767, 0, 0));
    // point on a hull edge
    send_points(pts(0, 0, 100, 0, 50, 0, 0, 100));
    send_points(pts(-32768, -32768, 32766, -32768, -1, -32768, 0, 32767));
    // collinear, then a near-collinear set
    send_points(pts(0, 0, 3, 3, 1, 1, 2, 2));
    send_points(pts(7, -32768, 7, 32767, 7, 0, 7, -1));
    send_points(pts(-32768, -32768, 32767, 32767, 0, 0, -1, -1));
    send_points(pts(-32768, -32768, 32767, 32766, 32767, 32767, 0, 0));
    // coincident points
    send_points(pts(5, 5, 5, 5, 9, 1, 9, 1));
    send_points(pts(1, 2, 1, 2, -4, 8, 1, 2));
    send_points(pts(0, 0, 10, 0, 0, 10, 10, 0));
    send_points(pts(2, 2, 0, 0, 9, 0, 2, 2));
  endtask

  task automatic test_random_points(input int count, input bit tx_gaps, input bit rx_gaps);
    tx_idle = tx_gaps;
    rx_idle = rx_gaps;
    repeat (count) send_points(rand_points());
  endtask

  // output held off long enough for the pipe to fill and push back on input
  task automatic test_input_stall();
    drain_results();
    tx_idle     = 1'b0;
    rx_idle     = 1'b0;
    rx_hold_req = 80;
    repeat (24) send_points(rand_points());
    rx_idle = 1'b1;
    tx_idle = 1'b1;
  endtask

  // bursts separated by a full drain
  task automatic test_drain_pause();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    repeat (4) begin
      repeat (8) send_points(rand_points());
      drain_results();
    end
  endtask

  task automatic finish_run();
    drain_results();
    repeat (8) @(posedge clk);
    $display("covered %0d point sets: %0d quad, %0d triangle, %0d collinear",
             sets_sent, layout_count[LAYOUT_QUAD], layout_count[LAYOUT_TRI],
             layout_count[LAYOUT_LINE]);
    $display("%0d results checked, %0d input stall cycles, %0d mismatches",
             results_seen, stall_cycles, mismatches);
    if (mismatches == 0 && pending_parts.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_shapes();
    test_random_points(400, 1'b1, 1'b1);
    test_input_stall();
    test_random_points(200, 1'b0, 1'b0);
    test_drain_pause();
    test_random_points(200, 1'b1, 1'b0);
    test_random_points(200, 1'b0, 1'b1);
    finish_run();
  end

endmodule

FILE: radon_partition_four_points.f
hw/rtl/rp4_pkg.sv
hw/rtl/rp4_lane.sv
hw/rtl/rp4_merge.sv
hw/rtl/radon_partition_four_points.sv
hw/rtl/rp4_checker.sv
test/radon_partition_four_points_tb.sv
